FILE: design/tga_rle_pixel_decoder_macros.svh
// Assertion macros used by the checker file of the decoder.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Checked property, masked while reset is held.
`define TGA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property, also active during reset.
`define TGA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tga_pkg.sv
// Shared constants, types and helper functions of the TGA RLE pixel decoder.
`timescale 1ns / 1ps

package tga_pkg;

    // Width of the running pixel counter; the image total saturates at 2**CountBits.
    localparam int CountBits = 24;
    localparam int TotW      = CountBits + 1;

    localparam int CfgW      = 25;
    localparam int QDepth    = 4;
    localparam int QPtrW     = $clog2(QDepth);
    localparam int QCntW     = $clog2(QDepth + 1);
    localparam int TdataW    = 72;

    localparam logic [6:0] HdrLenMask = 7'h7F;
    localparam int         HdrRunBit  = 7;

    typedef enum logic [0:0] {
        REG_PIXEL_BYTES = 1'b0,
        REG_PIXEL_TOTAL = 1'b1
    } t_reg_idx;

    // One decoded pixel and how many times it goes out.
    typedef struct packed {
        logic [31:0] pix;
        logic [7:0]  cnt;
        logic        done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Bytes per pixel: 0..2 gray, 3 RGB, 4..7 RGBA.
    function automatic logic [2:0] pix_size(input logic [2:0] pb);
        logic [2:0] s;
        if (pb <= 3'd2) begin
            s = 3'd1;
        end else if (pb == 3'd3) begin
            s = 3'd3;
        end else begin
            s = 3'd4;
        end
        return s;
    endfunction

    // Zero acts as one, large totals clamp to 2**CountBits.
    function automatic logic [TotW-1:0] eff_total(input logic [CfgW-1:0] t);
        logic [32:0] w;
        w = 33'(t);
        if (w == 33'd0) begin
            w = 33'd1;
        end
        if (w > (33'd1 << CountBits)) begin
            w = 33'd1 << CountBits;
        end
        return w[TotW-1:0];
    endfunction

endpackage

FILE: design/tga_front.sv
// Front end: header parsing, pixel assembly and image pixel accounting.
`timescale 1ns / 1ps

module tga_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [7:0]                   i_byte,
    input  logic [2:0]                   i_pixel_bytes,
    input  logic [tga_pkg::TotW-1:0]     i_total,
    input  tga_pkg::t_q_status           i_q_stat,
    output logic                         o_ready,
    output logic                         o_push,
    output tga_pkg::t_job                o_job
);

    logic                          r_expect, n_expect;
    logic                          r_run, n_run;
    logic [7:0]                    r_left, n_left;
    logic [31:0]                   r_asm, n_asm;
    logic [1:0]                    r_bip, n_bip;
    logic [tga_pkg::CountBits-1:0] r_pd, n_pd;

    logic                          accept;
    logic [2:0]                    size;
    logic [31:0]                   asm_new;
    logic [31:0]                   pix;
    logic [tga_pkg::TotW-1:0]      pd_ext;
    logic [tga_pkg::TotW-1:0]      remaining;
    logic [7:0]                    left_eff;
    logic [7:0]                    n_sel;
    logic [7:0]                    n_pix;
    logic                          finished;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign size    = tga_pkg::pix_size(i_pixel_bytes);

    // New byte lands at its lane; a fresh pixel starts from zero.
    assign asm_new = ((r_bip == 2'd0) ? 32'd0 : r_asm) | (32'(i_byte) << {r_bip, 3'b000});

    // Colour pixels arrive B,G,R(,A): swap lanes 0 and 2.
    assign pix = (size >= 3'd3) ? {asm_new[31:24], asm_new[7:0], asm_new[15:8], asm_new[23:16]}
                                : asm_new;

    assign pd_ext    = tga_pkg::TotW'(r_pd);
    assign remaining = (pd_ext >= i_total) ? tga_pkg::TotW'(1) : (i_total - pd_ext);
    assign left_eff  = (r_left == 8'd0) ? 8'd1 : r_left;
    assign n_sel     = r_run ? left_eff : 8'd1;
    assign finished  = (tga_pkg::TotW'(n_sel) >= remaining);
    assign n_pix     = finished ? remaining[7:0] : n_sel;

    always_comb begin
        n_expect = r_expect;
        n_run    = r_run;
        n_left   = r_left;
        n_asm    = r_asm;
        n_bip    = r_bip;
        n_pd     = r_pd;
        o_push   = 1'b0;
        o_job    = '{pix: pix, cnt: n_pix, done: finished};
        if (accept) begin
            if (r_expect) begin
                n_run    = i_byte[tga_pkg::HdrRunBit];
                n_left   = {1'b0, i_byte[6:0] & tga_pkg::HdrLenMask} + 8'd1;
                n_expect = 1'b0;
                n_bip    = 2'd0;
                n_asm    = 32'd0;
            end else begin
                n_asm = asm_new;
                if (({1'b0, r_bip} + 3'd1) < size) begin
                    n_bip = r_bip + 2'd1;
                end else begin
                    n_bip  = 2'd0;
                    o_push = 1'b1;
                    n_left = r_run ? 8'd0 : (left_eff - 8'd1);
                    n_pd   = r_pd + tga_pkg::CountBits'(n_pix);
                    if (finished) begin
                        n_expect = 1'b1;
                        n_run    = 1'b0;
                        n_left   = 8'd0;
                        n_pd     = '0;
                    end else if (n_left == 8'd0) begin
                        n_expect = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 1'b1;
            r_run    <= 1'b0;
            r_left   <= 8'd0;
            r_asm    <= 32'd0;
            r_bip    <= 2'd0;
            r_pd     <= '0;
        end else begin
            r_expect <= n_expect;
            r_run    <= n_run;
            r_left   <= n_left;
            r_asm    <= n_asm;
            r_bip    <= n_bip;
            r_pd     <= n_pd;
        end
    end

endmodule

FILE: design/tga_queue.sv
// Small job queue between the front end and the output expander.
`timescale 1ns / 1ps

module tga_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tga_pkg::t_job      i_job,
    input  logic               i_pop,
    output tga_pkg::t_job      o_job,
    output tga_pkg::t_q_status o_stat
);

    tga_pkg::t_job              r_mem [tga_pkg::QDepth];
    logic [tga_pkg::QPtrW-1:0]  r_wr, n_wr;
    logic [tga_pkg::QPtrW-1:0]  r_rd, n_rd;
    logic [tga_pkg::QCntW-1:0]  r_cnt, n_cnt;
    logic                       do_push;
    logic                       do_pop;

    assign o_stat.full  = (r_cnt == tga_pkg::QCntW'(tga_pkg::QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/tga_back.sv
// Back end: expands queued pixels into output beats of one or two pixels.
`timescale 1ns / 1ps

module tga_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tga_pkg::t_job              i_job,
    input  tga_pkg::t_q_status         i_q_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [tga_pkg::TdataW-1:0] o_data,
    output logic                       o_last
);

    logic                       r_busy, n_busy;
    tga_pkg::t_job              r_job, n_job;
    logic                       r_valid, n_valid;
    logic [tga_pkg::TdataW-1:0] r_data, n_data;
    logic                       r_last, n_last;

    logic                       out_free;
    logic                       fire;
    logic [7:0]                 take;
    logic [7:0]                 left_after;

    assign out_free   = !r_valid || i_ready;
    assign fire       = r_busy && out_free;
    assign take       = (r_job.cnt >= 8'd2) ? 8'd2 : 8'd1;
    assign left_after = r_job.cnt - take;
    assign o_pop      = !i_q_stat.empty && (!r_busy || (fire && left_after == 8'd0));

    always_comb begin
        n_busy  = r_busy;
        n_job   = r_job;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (fire) begin
            n_valid = 1'b1;
            n_data  = {6'd0, take[1:0], (take == 8'd2) ? r_job.pix : 32'd0, r_job.pix};
            n_last  = r_job.done && (left_after == 8'd0);
            n_job.cnt = left_after;
            if (left_after == 8'd0) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
        r_job  <= n_job;
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

FILE: design/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
//
//   Channel   Dir  Beat content                          Handshake
//   s_axis    in   tdata[7:0] stream_byte                tvalid/tready
//   m_axis    out  tdata: pixel_first, second, count     tvalid/tready, tlast=image_done
//   cfg       in   i_cfg_addr selects register, data     i_cfg_we, no wait
//
// Cycles: one stream byte per cycle while the job queue has room. Each completed
// pixel is one job; the back end sends ceil(n/2) beats for it, one per cycle while m_axis_tready holds, and
// the input stalls once the four-entry queue fills behind a long run.
// Reset: synchronous, active low; clears the parser, queue pointers and output
// valid. No clearing pass; beats are accepted right after reset.
// Stalls: front end only on a full queue, back end only on m_axis_tready.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // stream in
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] stream_byte
    // pixels out
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [31:0] pixel_first, [63:32] pixel_second, [65:64] pixel_count, rest zero
    output logic [tga_pkg::TdataW-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,   // image_done
    // configuration
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_addr,
    input  logic [tga_pkg::CfgW-1:0]    i_cfg_data
);

    logic [2:0]               r_pixel_bytes;
    logic [tga_pkg::TotW-1:0] r_total;   // already clamped total

    tga_pkg::t_job      push_job;
    tga_pkg::t_job      head_job;
    tga_pkg::t_q_status q_stat;
    logic               push;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= 3'd3;
            r_total       <= tga_pkg::TotW'(1);
        end else if (i_cfg_we) begin
            case (tga_pkg::t_reg_idx'(i_cfg_addr))
                tga_pkg::REG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[2:0];
                tga_pkg::REG_PIXEL_TOTAL: r_total <= tga_pkg::eff_total(i_cfg_data);
                default: ;
            endcase
        end
    end

    tga_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_pixel_bytes (r_pixel_bytes),
        .i_total       (r_total),
        .i_q_stat      (q_stat),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_job         (push_job)
    );

    tga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    tga_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

FILE: design/tga_chk.sv
// Port-level checker for the decoder, bound to the top level.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"

module tga_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [tga_pkg::TdataW-1:0] m_axis_tdata,
    input logic                       m_axis_tlast
);

    // A stalled beat keeps its payload.
    `TGA_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")

    `TGA_ASSERT(a_count, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[65:64] == 2'd1 || m_axis_tdata[65:64] == 2'd2), "pixel count not 1 or 2")

    // Single-pixel beats leave the second slot cleared.
    `TGA_ASSERT(a_second, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[65:64] == 2'd1 |-> m_axis_tdata[63:32] == 32'd0, "second pixel not zero")

    `TGA_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind tga_rle_pixel_decoder tga_chk u_tga_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
